// ===== src/ists_pkg.sv =====
// ----------------------------------------------------------------------------
// ists_pkg
// Shared types and constants of the icon scaler with luma tint.
// ----------------------------------------------------------------------------
package ists_pkg;

	localparam int SRC_STORE_DEPTH_DEF = 1024;
	localparam int MAX_TARGET_SIDE     = 80;
	localparam int MIN_TARGET_SIDE     = 6;
	localparam int SCALE_MIN           = 8;
	localparam int SCALE_MAX           = 64;
	localparam int QUEUE_DEPTH_DEF     = 16;
	localparam int OUT_DEPTH_DEF       = 8;

	localparam int ADDR_W = 12;   // widest store address (4096 entries)
	localparam int QUOT_W = 6;    // source coordinate bits
	localparam int NUM_W  = 13;   // out coordinate times source size

	// luma weights: 8*30, 4*59, 8*11
	localparam int W_RED   = 240;
	localparam int W_GREEN = 236;
	localparam int W_BLUE  = 88;

	// n/100 = (n*5243)>>19, exact for n < 43690
	localparam int LUMA_RECIP = 5243;
	localparam int LUMA_SHIFT = 19;
	// n/255 = (n*16449)>>22, exact for n < 21959
	localparam int CH_RECIP = 16449;
	localparam int CH_SHIFT = 22;

	localparam logic [15:0] KEY_FLIP = 16'h0001;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_SCALE      = 3'd2,
		REG_TINT_EN    = 3'd3,
		REG_TINT_COLOR = 3'd4,
		REG_KEY        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [5:0]  src_w;
		logic [5:0]  src_h;
		logic        tint_en;
		logic [15:0] tint;
		logic [15:0] key;
		logic [6:0]  tw;
		logic [6:0]  th;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic              is_load;
		logic              in_range;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} qentry_t;

	typedef struct packed {
		logic              is_load;
		logic              in_range;
		logic [9:0]        idx;
		logic [15:0]       data;
		logic [NUM_W-1:0]  rx;
		logic [NUM_W-1:0]  ry;
		logic [QUOT_W-1:0] qx;
		logic [QUOT_W-1:0] qy;
	} dstage_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        transparent;
		logic        in_range;
	} result_t;

endpackage

// ===== src/ists_ram.sv =====
// ----------------------------------------------------------------------------
// ists_ram
// Single-port RAM, write or read each cycle, registered read data.
// ----------------------------------------------------------------------------
module ists_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/ists_fifo.sv =====
// ----------------------------------------------------------------------------
// ists_fifo
// Small synchronous FIFO with show-ahead head and occupancy count.
// ----------------------------------------------------------------------------
module ists_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       din,
	input  logic                   pop,
	output logic [WIDTH-1:0]       dout,
	output logic                   empty,
	output logic [$clog2(DEPTH):0] count
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;
endmodule

// ===== src/ists_front.sv =====
// ----------------------------------------------------------------------------
// ists_front
// Accepts items, scales fetch coordinates back to the source grid through a
// pipelined divider and forms the store address.
// ----------------------------------------------------------------------------
module ists_front #(
	parameter int DEPTH  = ists_pkg::SRC_STORE_DEPTH_DEF,
	parameter int QDEPTH = ists_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [9:0]               src_index,
	input  logic [15:0]              src_pixel,
	input  logic [6:0]               out_x,
	input  logic [6:0]               out_y,
	input  ists_pkg::cfg_t           cfg,
	input  logic [$clog2(QDEPTH):0]  q_count,
	output logic                     push,
	output ists_pkg::qentry_t        push_entry
);
	import ists_pkg::*;

	logic              v_s1;
	dstage_t           d_s1;
	logic [QUOT_W-1:0] v_div;
	dstage_t           div_s [QUOT_W];
	logic              v_s2;
	qentry_t           e_s2;
	logic [3:0]        inflight;
	logic              accept;

	assign inflight = 4'(v_s1) + 4'($countones(v_div)) + 4'(v_s2);
	// credit: everything in flight must fit in the queue
	assign in_ready = (32'(q_count) + 32'(inflight)) < 32'(QDEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		d_s1.is_load  <= ~opcode;
		d_s1.in_range <= (out_x < cfg.tw) && (out_y < cfg.th);
		d_s1.idx      <= src_index;
		d_s1.data     <= src_pixel;
		d_s1.rx       <= NUM_W'(out_x) * NUM_W'(cfg.src_w);
		d_s1.ry       <= NUM_W'(out_y) * NUM_W'(cfg.src_h);
		d_s1.qx       <= '0;
		d_s1.qy       <= '0;
	end

	// divider valid bits shift along with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_div <= '0;
		else         v_div <= {v_div[QUOT_W-2:0], v_s1};
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		dstage_t          din;
		dstage_t          dnx;
		logic [NUM_W-1:0] tx;
		logic [NUM_W-1:0] ty;
		logic             gx;
		logic             gy;

		if (k == 0) begin : g_first
			assign din = d_s1;
		end else begin : g_next
			assign din = div_s[k-1];
		end

		assign tx = NUM_W'(cfg.tw) << (QUOT_W - 1 - k);
		assign ty = NUM_W'(cfg.th) << (QUOT_W - 1 - k);
		assign gx = din.rx >= tx;
		assign gy = din.ry >= ty;

		always_comb begin
			dnx    = din;
			dnx.rx = gx ? din.rx - tx : din.rx;
			dnx.ry = gy ? din.ry - ty : din.ry;
			dnx.qx = {din.qx[QUOT_W-2:0], gx};
			dnx.qy = {din.qy[QUOT_W-2:0], gy};
		end

		always_ff @(posedge clk) begin
			div_s[k] <= dnx;
		end
	end

	logic [NUM_W-1:0] addr_full;
	dstage_t          dl;

	assign dl        = div_s[QUOT_W-1];
	assign addr_full = NUM_W'(dl.qy) * NUM_W'(cfg.src_w) + NUM_W'(dl.qx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_div[QUOT_W-1];
	end

	always_ff @(posedge clk) begin
		e_s2.is_load  <= dl.is_load;
		e_s2.in_range <= dl.in_range;
		e_s2.wr_en    <= dl.is_load && (32'(dl.idx) < 32'(DEPTH));
		e_s2.addr     <= dl.is_load ? ADDR_W'(dl.idx) : addr_full[ADDR_W-1:0];
		e_s2.data     <= dl.data;
	end

	assign push       = v_s2;
	assign push_entry = e_s2;
endmodule

// ===== src/ists_back.sv =====
// ----------------------------------------------------------------------------
// ists_back
// Store access in item order, key test, luma and tint pipeline.
// ----------------------------------------------------------------------------
module ists_back #(
	parameter int DEPTH  = ists_pkg::SRC_STORE_DEPTH_DEF,
	parameter int ODEPTH = ists_pkg::OUT_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  ists_pkg::qentry_t       q_head,
	output logic                    pop,
	input  ists_pkg::cfg_t          cfg,
	input  logic [$clog2(ODEPTH):0] o_count,
	output logic                    push,
	output ists_pkg::result_t       result
);
	import ists_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [2:0]  inflight;
	logic [15:0] rdata;
	logic        load_s1, inr_s1;

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign pop = !q_empty && ((32'(o_count) + 32'(inflight)) < 32'(ODEPTH));

	// loads and reads share one port, so store order follows item order
	ists_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (pop && q_head.wr_en),
		.addr  (q_head.addr[AW-1:0]),
		.wdata (q_head.data),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		load_s1 <= q_head.is_load;
		inr_s1  <= q_head.in_range;
	end

	// stage 2: weighted sum
	logic [14:0] sum_s2;
	logic [15:0] p_s2;
	logic        key_s2, live_s2;

	always_ff @(posedge clk) begin
		sum_s2  <= 15'(rdata[15:11]) * 15'(W_RED) + 15'(rdata[10:5]) * 15'(W_GREEN)
		         + 15'(rdata[4:0]) * 15'(W_BLUE);
		p_s2    <= rdata;
		key_s2  <= rdata == cfg.key;
		live_s2 <= !load_s1 && inr_s1;
	end

	// stage 3: luma = sum / 100
	logic [27:0] lprod;
	logic [7:0]  luma_s3;
	logic [15:0] p_s3;
	logic        key_s3, live_s3;

	assign lprod = 28'(sum_s2) * 28'(LUMA_RECIP);

	always_ff @(posedge clk) begin
		luma_s3 <= lprod[LUMA_SHIFT +: 8];
		p_s3    <= p_s2;
		key_s3  <= key_s2;
		live_s3 <= live_s2;
	end

	// stage 4: tint channel times luma
	logic [13:0] pr_s4, pg_s4, pb_s4;
	logic [15:0] p_s4;
	logic        key_s4, live_s4;

	always_ff @(posedge clk) begin
		pr_s4   <= 14'(cfg.tint[15:11]) * 14'(luma_s3);
		pg_s4   <= 14'(cfg.tint[10:5]) * 14'(luma_s3);
		pb_s4   <= 14'(cfg.tint[4:0]) * 14'(luma_s3);
		p_s4    <= p_s3;
		key_s4  <= key_s3;
		live_s4 <= live_s3;
	end

	// stage 5 (into output FIFO): channel / 255, repack, select
	logic [28:0] cr, cg, cb;
	logic [15:0] tinted, tfix;

	assign cr     = 29'(pr_s4) * 29'(CH_RECIP);
	assign cg     = 29'(pg_s4) * 29'(CH_RECIP);
	assign cb     = 29'(pb_s4) * 29'(CH_RECIP);
	assign tinted = {cr[CH_SHIFT +: 5], cg[CH_SHIFT +: 6], cb[CH_SHIFT +: 5]};
	assign tfix   = (tinted == cfg.key) ? (tinted ^ KEY_FLIP) : tinted;

	always_comb begin
		result.in_range    = live_s4;
		result.transparent = 1'b0;
		result.pixel       = '0;
		priority if (!live_s4) begin
			result.in_range = 1'b0;
		end else if (key_s4) begin
			result.transparent = 1'b1;
			result.pixel       = p_s4;
		end else if (cfg.tint_en) begin
			result.pixel = tfix;
		end else begin
			result.pixel = p_s4;
		end
	end

	assign push = v_s4;
endmodule

// ===== src/icon_scale_tint_rgb565_core.sv =====
// Throughput: one beat per cycle, sustained; the front credit against the
// 16-entry queue and the back credit against the 8-entry output FIFO pace it.
// Reset: arst_n clears all control state and loads the register defaults;
// the source store is not cleared and reads back undefined until written.
// ----------------------------------------------------------------------------
// icon_scale_tint_rgb565_core
// Nearest-neighbor RGB565 icon scaler with transparent key and luma tint.
// ----------------------------------------------------------------------------
module icon_scale_tint_rgb565_core #(
	parameter int SRC_STORE_DEPTH = ists_pkg::SRC_STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // src_index[9:0], src_pixel[25:10], out_x[32:26], out_y[39:33]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel[15:0], target_width[22:16], target_height[29:23]
	output logic [1:0]  m_tuser,   // transparent[0], in_range[1]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ists_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int ODEPTH = OUT_DEPTH_DEF;

	logic [5:0]  src_w_q, src_h_q;
	logic [6:0]  scale_q;
	logic        tint_en_q;
	logic [15:0] tint_q, key_q;
	logic [6:0]  tw, th;
	reg_idx_t    ridx;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= 6'd20;
			src_h_q   <= 6'd20;
			scale_q   <= 7'd16;
			tint_en_q <= 1'b0;
			tint_q    <= 16'h0000;
			key_q     <= 16'h1904;
		end else if (wr) begin
			unique case (ridx)
				REG_SRC_WIDTH:  src_w_q   <= pwdata[5:0];
				REG_SRC_HEIGHT: src_h_q   <= pwdata[5:0];
				REG_SCALE:      scale_q   <= pwdata[6:0];
				REG_TINT_EN:    tint_en_q <= pwdata[0];
				REG_TINT_COLOR: tint_q    <= pwdata[15:0];
				REG_KEY:        key_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SRC_WIDTH:  prdata = 32'(src_w_q);
			REG_SRC_HEIGHT: prdata = 32'(src_h_q);
			REG_SCALE:      prdata = 32'(scale_q);
			REG_TINT_EN:    prdata = 32'(tint_en_q);
			REG_TINT_COLOR: prdata = 32'(tint_q);
			REG_KEY:        prdata = 32'(key_q);
			default:        prdata = '0;
		endcase
	end

	function automatic logic [6:0] target_side(input logic [5:0] src, input logic [6:0] sc);
		logic [6:0]  s;
		logic [12:0] t;
		s = sc;
		if (s < 7'(SCALE_MIN)) s = 7'(SCALE_MIN);
		if (s > 7'(SCALE_MAX)) s = 7'(SCALE_MAX);
		t = (13'(src) * 13'(s)) >> 4;
		if (t < 13'(MIN_TARGET_SIDE)) t = 13'(MIN_TARGET_SIDE);
		if (t > 13'(MAX_TARGET_SIDE)) t = 13'(MAX_TARGET_SIDE);
		return t[6:0];
	endfunction

	// target size follows the registers at once, so a beat right after a write sees it
	assign tw = target_side(src_w_q, scale_q);
	assign th = target_side(src_h_q, scale_q);

	cfg_t cfg;
	assign cfg = '{src_w: src_w_q, src_h: src_h_q, tint_en: tint_en_q, tint: tint_q,
	               key: key_q, tw: tw, th: th};

	logic                   q_push, q_pop, q_empty;
	qentry_t                q_in, q_head;
	logic [$clog2(QDEPTH):0] q_count;

	ists_front #(.DEPTH(SRC_STORE_DEPTH), .QDEPTH(QDEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (s_tuser),
		.src_index  (s_tdata[9:0]),
		.src_pixel  (s_tdata[25:10]),
		.out_x      (s_tdata[32:26]),
		.out_y      (s_tdata[39:33]),
		.cfg        (cfg),
		.q_count    (q_count),
		.push       (q_push),
		.push_entry (q_in)
	);

	ists_fifo #(.WIDTH($bits(qentry_t)), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty),
		.count  (q_count)
	);

	logic                    o_push, o_empty;
	result_t                 o_in, o_head;
	logic [$clog2(ODEPTH):0] o_count;

	ists_back #(.DEPTH(SRC_STORE_DEPTH), .ODEPTH(ODEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (q_pop),
		.cfg     (cfg),
		.o_count (o_count),
		.push    (o_push),
		.result  (o_in)
	);

	ists_fifo #(.WIDTH($bits(result_t)), .DEPTH(ODEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push),
		.din    (o_in),
		.pop    (m_tvalid && m_tready),
		.dout   (o_head),
		.empty  (o_empty),
		.count  (o_count)
	);

	assign m_tvalid = !o_empty;
	assign m_tdata  = {2'b00, th, tw, o_head.pixel};
	assign m_tuser  = {o_head.in_range, o_head.transparent};
endmodule
